// ===== hw/rtl/kdr_pkg.sv =====
// Shared types and constants for the keypad debounce and auto-repeat block.
`default_nettype none
package kdr_pkg;

    localparam int KEY_SLOTS  = 8;
    localparam int CNT_W      = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 1'd1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd4;
    localparam logic [CNT_W-1:0] REPEAT_RST   = 8'd100;

    typedef enum logic [1:0] {
        KIND_DOWN   = 2'd0,
        KIND_UP     = 2'd1,
        KIND_REPEAT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CNT_W-1:0] debounce;
        logic [CNT_W-1:0] repeat_lim;
    } t_limits;

    typedef struct packed {
        logic  sel;   // lowest pending event in the row
        logic  last;  // no pending event above this cell
        t_kind kind;
    } t_cell_out;

endpackage
`default_nettype wire

// ===== hw/rtl/kdr_in_if.sv =====
// Tick channel: one beat per polling tick, one released bit per key.
`default_nettype none
interface kdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_released;

    modport source (output valid, output key_released, input ready);
    modport sink   (input valid, input key_released, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kdr_out_if.sv =====
// Event channel: one beat per key event.
`default_nettype none
interface kdr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [2:0] key_index;
    logic       last_event;

    modport source (output valid, output event_kind, output key_index, output last_event,
                    input ready);
    modport sink   (input valid, input event_kind, input key_index, input last_event,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/keypad_debounce_repeat_unit.sv =====
// Top level: keypad debounce with auto-repeat, a row of key cells and an event register.
// A tick beat updates every key cell at its accept edge; the first event of that
//   tick is loaded into the output register once that register is free.
// Throughput: one event beat per cycle while the sink is ready; a tick with events holds
//   off the next tick while its pending events drain, a quiet tick does not.
// Reset (synchronous, active low): counters, pressed flags and pending events clear,
//   debounce limit returns to 4 and repeat limit to 100, output register empties.
`default_nettype none
module keypad_debounce_repeat_unit #(
    parameter int NUM_KEYS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kdr_in_if.sink                              i_key,
    kdr_out_if.source                           o_evt
);
    import kdr_pkg::*;

    // keys above the eight the tick word holds are never scanned
    localparam int NK = (NUM_KEYS > KEY_SLOTS) ? KEY_SLOTS : NUM_KEYS;

    // limit registers
    t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.debounce   <= DEBOUNCE_RST;
            r_limits.repeat_lim <= REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_limits.debounce   <= i_cfg_data;
                CFG_REPEAT:   r_limits.repeat_lim <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // cell row: lower[] carries "a lower key has an event pending" upward,
    // upper[] carries "a higher key has an event pending" downward
    logic [NK:0]     lower;
    logic [NK:0]     upper;
    logic [NK-1:0]   take;
    logic [NK-1:0]   sel_vec;
    t_cell_out       status [NK];
    logic            any_pend;
    logic            tick;
    logic            load;

    assign lower[0]  = 1'b0;
    assign upper[NK] = 1'b0;
    assign any_pend  = lower[NK];

    // a new tick waits until every event of the previous one left the row
    assign i_key.ready = ~any_pend;
    assign tick        = i_key.valid & ~any_pend;

    genvar g;
    generate
        for (g = 0; g < NK; g++) begin : g_cell
            kdr_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_tick     (tick),
                .i_released (i_key.key_released[g]),
                .i_limits   (r_limits),
                .i_take     (take[g]),
                .i_lower    (lower[g]),
                .o_lower    (lower[g+1]),
                .i_upper    (upper[g+1]),
                .o_upper    (upper[g]),
                .o_status   (status[g])
            );
            assign sel_vec[g] = status[g].sel;
            assign take[g]    = status[g].sel & load;
        end
    endgenerate

    // pick the lowest pending cell; sel_vec is one-hot or empty
    logic [KEY_IDX_W-1:0] sel_idx;
    logic [1:0]           sel_kind;
    logic                 sel_last;

    always_comb begin
        sel_idx  = '0;
        sel_kind = '0;
        sel_last = 1'b0;
        for (int k = 0; k < NK; k++) begin
            if (status[k].sel) begin
                sel_idx  = sel_idx | KEY_IDX_W'(k);
                sel_kind = sel_kind | status[k].kind;
                sel_last = sel_last | status[k].last;
            end
        end
    end

    // event register
    logic                 r_out_valid;
    logic [1:0]           r_out_kind;
    logic [KEY_IDX_W-1:0] r_out_idx;
    logic                 r_out_last;

    assign load = any_pend & (~r_out_valid | o_evt.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= sel_kind;
            r_out_idx  <= sel_idx;
            r_out_last <= sel_last;
        end
    end

    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_kind = r_out_kind;
    assign o_evt.key_index  = r_out_idx;
    assign o_evt.last_event = r_out_last;

    // at most one cell wins the output
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(sel_vec))
        else $error("more than one key cell selected");

    // both ends of the row see the same "anything pending"
    a_chains_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upper[0] == any_pend)
        else $error("priority chains disagree");

    // once the marked beat is loaded, nothing of that tick is left in the row
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && sel_last |=> !any_pend)
        else $error("events left pending after last beat");

    // an unmarked beat in the register means more events of its tick still wait
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> any_pend)
        else $error("non-last beat with nothing pending");

    // a tick is never taken while events are queued in the row
    a_no_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick |-> !load)
        else $error("tick accepted while draining");

endmodule
`default_nettype wire

// ===== hw/rtl/kdr_cell.sv =====
// One key cell: hold counter, pressed flag, pending event and priority links.
`default_nettype none
module kdr_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tick,
    input  wire logic               i_released,
    input  wire kdr_pkg::t_limits   i_limits,
    input  wire logic               i_take,
    input  wire logic               i_lower,
    output logic                    o_lower,
    input  wire logic               i_upper,
    output logic                    o_upper,
    output kdr_pkg::t_cell_out      o_status
);
    import kdr_pkg::*;

    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_flag, n_flag;
    logic             r_pend, n_pend;
    t_kind            r_kind, n_kind;
    logic [CNT_W-1:0] inc;

    assign inc = r_cnt + CNT_W'(1);

    always_comb begin
        n_cnt  = r_cnt;
        n_flag = r_flag;
        n_pend = r_pend;
        n_kind = r_kind;
        if (i_tick) begin
            if (i_released) begin
                n_cnt = '0;
                if (r_flag) begin
                    n_flag = 1'b0;
                    n_pend = 1'b1;
                    n_kind = KIND_UP;
                end
            end else if (r_flag) begin
                if (inc > i_limits.repeat_lim) begin
                    n_cnt  = '0;
                    n_pend = 1'b1;
                    n_kind = KIND_REPEAT;
                end else begin
                    n_cnt = inc;
                end
            end else if (inc > i_limits.debounce) begin
                n_cnt  = '0;
                n_flag = 1'b1;
                n_pend = 1'b1;
                n_kind = KIND_DOWN;
            end else begin
                n_cnt = inc;
            end
        end else if (i_take) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_flag <= 1'b0;
            r_pend <= 1'b0;
            r_kind <= KIND_DOWN;
        end else begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
            r_pend <= n_pend;
            r_kind <= n_kind;
        end
    end

    // priority runs up from key 0, the last-event mark runs down from the top key
    assign o_lower       = i_lower | r_pend;
    assign o_upper       = i_upper | r_pend;
    assign o_status.sel  = r_pend & ~i_lower;
    assign o_status.last = ~i_upper;
    assign o_status.kind = r_kind;

endmodule
`default_nettype wire

// ===== sim/key_event_checker.sv =====
// Checker: predicts key events from tick beats and compares them with event beats.
`default_nettype none
module key_event_checker #(
    parameter int NUM_KEYS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_run_done,
    kdr_in_if                                   i_tick,
    kdr_out_if                                  i_evt,
    output int                                  o_fail_count,
    output int                                  o_outstanding,
    output int                                  o_events_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import kdr_pkg::*;

    localparam int SCAN_KEYS   = (NUM_KEYS < KEY_SLOTS) ? NUM_KEYS : KEY_SLOTS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_kind                kind;
        logic [KEY_IDX_W-1:0] key;
        logic                 last;
    } t_key_event;

    logic [CNT_W-1:0]     hold_cnt [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] pressed;
    t_limits              limits;
    t_key_event           pending_events [$];
    bit                   leftovers_done = 1'b0;

    function automatic t_key_event make_event(input t_kind kind, input int k);
        t_key_event ev;
        ev.kind = kind;
        ev.key  = KEY_IDX_W'(k);
        ev.last = 1'b0;
        return ev;
    endfunction

    // One polling tick: walk the keys upward, at most one event per key.
    task automatic debounce_scan(input logic [KEY_SLOTS-1:0] released);
        t_key_event tick_events [KEY_SLOTS];
        int         n_ev;
        int         k;
        n_ev = 0;
        for (k = 0; k < SCAN_KEYS; k++) begin
            if (released[k]) begin
                hold_cnt[k] = '0;
                if (pressed[k]) begin
                    pressed[k] = 1'b0;
                    tick_events[n_ev++] = make_event(KIND_UP, k);
                end
            end else begin
                hold_cnt[k] = hold_cnt[k] + 1'b1;   // wraps at 8 bits before the compare
                if (pressed[k]) begin
                    if (hold_cnt[k] > limits.repeat_lim) begin
                        hold_cnt[k] = '0;
                        tick_events[n_ev++] = make_event(KIND_REPEAT, k);
                    end
                end else if (hold_cnt[k] > limits.debounce) begin
                    hold_cnt[k] = '0;
                    pressed[k]  = 1'b1;
                    tick_events[n_ev++] = make_event(KIND_DOWN, k);
                end
            end
        end
        if (n_ev > 0) tick_events[n_ev-1].last = 1'b1;
        for (k = 0; k < n_ev; k++) pending_events.push_back(tick_events[k]);
    endtask

    task automatic compare_event();
        t_key_event want;
        o_events_checked++;
        if (pending_events.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: unexpected event beat: kind %0d key %0d last %0d", $time,
                         i_evt.event_kind, i_evt.key_index, i_evt.last_event);
        end else begin
            want = pending_events.pop_front();
            if (i_evt.event_kind !== want.kind || i_evt.key_index !== want.key ||
                i_evt.last_event !== want.last) begin
                o_fail_count++;
                if (o_fail_count <= MAX_REPORTS)
                    $display({"%0t: event mismatch: expected kind %0d key %0d last %0d,",
                              " got %0d %0d %0d"},
                             $time, want.kind, want.key, want.last,
                             i_evt.event_kind, i_evt.key_index, i_evt.last_event);
            end
        end
    endtask

    // Event side first: an event beat never belongs to a tick taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (hold_cnt[k]) hold_cnt[k] = '0;
            pressed           = '0;
            limits.debounce   = DEBOUNCE_RST;
            limits.repeat_lim = REPEAT_RST;
            pending_events.delete();
        end else begin
            if (i_evt.valid && i_evt.ready) compare_event();
            if (i_tick.valid && i_tick.ready) debounce_scan(i_tick.key_released);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE: limits.debounce   = i_cfg_data;
                    CFG_REPEAT:   limits.repeat_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_run_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (pending_events.size() != 0) begin
                    o_fail_count += pending_events.size();
                    $display("%0t: %0d expected events never arrived", $time,
                             pending_events.size());
                end
            end
        end
        o_outstanding = pending_events.size();
    end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the keypad debounce testbench: clock, reset, tick and limit stimulus, verdict.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kdr_pkg::*;

    localparam int NUM_KEYS      = 8;
    // The limit sits well above the slowest run (8 events per tick, each behind a sink
    // stall, plus sender gaps, the long stall and the settle pauses).
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_STALL    = 300;   // sink hold-off, long enough to back up the ticks
    localparam int SETTLE_CYCLES = 12;    // idle gap before the limits change

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic run_done = 1'b0;
    int   fail_count;
    int   outstanding;
    int   events_checked;
    int   cycle_count   = 0;
    int   ticks_sent    = 0;
    int   settings_used = 0;
    bit   quiet_tail    = 1'b0;   // final stretch: no idling on either side
    bit   stall_req     = 1'b0;   // asks the sink for one long hold-off

    // Keys currently held down (pin reads pressed); a tick beat carries the inverse.
    logic [KEY_SLOTS-1:0] held = '0;

    kdr_in_if  tick_ch ();
    kdr_out_if evt_ch ();

    keypad_debounce_repeat_unit #(
        .NUM_KEYS (NUM_KEYS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (tick_ch),
        .o_evt      (evt_ch)
    );

    key_event_checker #(
        .NUM_KEYS (NUM_KEYS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_run_done       (run_done),
        .i_tick           (tick_ch),
        .i_evt            (evt_ch),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_events_checked (events_checked)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Event sink: ready moves only at falling edges. Random stall bursts, one long
    // hold-off on request (counted here while the sender keeps pushing ticks).
    initial begin : event_sink
        int burst;
        evt_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                evt_ch.ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge i_clk);
                stall_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                evt_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                evt_ch.ready <= 1'b1;
            end
        end
    end

    // One tick beat. Entered and left at a falling edge; valid stays up between
    // back-to-back beats so it is never dropped and raised in the same step.
    task automatic send_tick(input logic [KEY_SLOTS-1:0] released);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.key_released <= released;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Sender pause: drop valid, wait for every expected event, then idle
    // before anything touches the limits.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] deb,
                              input logic [CFG_DATA_W-1:0] rep);
        settle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_REPEAT, rep);
        settings_used++;
    endtask

    // Realistic key activity: each key flips with odds 1/flip_odds per tick, so keys
    // stay held long enough to debounce and repeat. One beat in ten is pin noise.
    task automatic random_ticks(input int count, input int flip_odds);
        logic [KEY_SLOTS-1:0] flips;
        int                   k;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_tick(KEY_SLOTS'($urandom));
            end else begin
                flips = '0;
                for (k = 0; k < KEY_SLOTS; k++)
                    if ($urandom_range(0, flip_odds - 1) == 0) flips[k] = 1'b1;
                held ^= flips;
                send_tick(~held);
            end
        end
    endtask

    initial begin : stimulus
        tick_ch.valid        = 1'b0;
        tick_ch.key_released = '1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limits (4 / 100): all keys debounce together, release together,
        // then single keys at both ends of the row and alternating patterns.
        send_tick(8'hFF);                  // quiet tick
        repeat (6) send_tick(8'h00);       // 5th beat: eight downs, key 7 marked last
        send_tick(8'hFF);                  // eight ups
        repeat (5) send_tick(8'hFE);       // key 0 alone goes down
        repeat (5) send_tick(8'h7F);       // key 0 up, then key 7 down
        send_tick(8'h55);
        send_tick(8'hAA);                  // key 7 up
        send_tick(8'hFF);

        // Zero limits: down on the first held tick, repeat on every one after.
        set_limits(8'd0, 8'd0);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h5A);

        random_ticks(5, 4);

        // Long sink hold-off while ticks keep coming: the event path backs up and
        // the tick input stalls.
        set_limits(8'd1, 8'd3);
        stall_req = 1'b1;
        random_ticks(8, 6);

        set_limits(8'd2, 8'd6);
        random_ticks(5, 8);

        set_limits(8'd0, 8'd255);
        random_ticks(4, 5);

        // Counter wrap: with both limits at 255 no count can exceed them. Key 0 is held
        // for 256 ticks so its count wraps back to zero; the next phase has debounce 1,
        // so key 0 must need two more held ticks for its down event.
        set_limits(8'd255, 8'd255);
        send_tick('1);
        repeat (256) begin
            held = KEY_SLOTS'($urandom) | KEY_SLOTS'(1);
            send_tick(~held);
        end
        held = KEY_SLOTS'(1);

        set_limits(8'd1, CFG_DATA_W'($urandom_range(0, 10)));
        random_ticks(5, 8);

        set_limits(CFG_DATA_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom_range(0, 12)));
        random_ticks(5, 6);

        // Last stretch at full rate on both sides.
        set_limits(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 8)));
        quiet_tail = 1'b1;
        random_ticks(10, 6);

        settle();
        run_done <= 1'b1;
        repeat (2) @(negedge i_clk);

        $display("summary: %0d tick beats, %0d event beats checked, %0d limit settings",
                 ticks_sent, events_checked, settings_used + 1);
        $display("summary: limits 0 and 255 on both registers, long sink stall, 8-bit wrap");
        if (fail_count == 0 && outstanding == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
